>>> hdl/arma_pkg.sv
// ----------------------------------------------------------------------------
// arma_pkg
// Shared constants for the accelerometer axis remap and moving average block.
// ----------------------------------------------------------------------------
package arma_pkg;

  // parameter defaults
  localparam int WINDOW_MAX_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // configuration port
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int BIAS_W     = 16;
  localparam int WLEN_W     = 7;
  localparam int WLEN_RESET = 8;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_ROTATION   = 2'd0;
  localparam cfg_idx_t REG_X_BIAS     = 2'd1;
  localparam cfg_idx_t REG_WINDOW_LEN = 2'd2;

  // rotation codes
  typedef logic [1:0] rot_t;

  localparam rot_t ROT_0   = 2'd0;
  localparam rot_t ROT_90  = 2'd1;
  localparam rot_t ROT_180 = 2'd2;
  localparam rot_t ROT_270 = 2'd3;

endpackage

>>> hdl/accel_rotate_moving_average.sv
// ----------------------------------------------------------------------------
// accel_rotate_moving_average
// Remaps device X/Y to world axes by screen rotation, negates world X and
// adds a bias, keeps a sliding window of recent samples and emits per-axis
// means, truncated toward zero and saturated to the sample range.
// ----------------------------------------------------------------------------
// A beat passes through the states SUB, ADD, LOAD, DIV and OUT; the input
// stalls until its result is loaded into the output register. Division uses
//   bit-serial restoring dividers (one quotient bit per cycle, three axes in parallel).
// Reset (rst_n low, synchronous): rotation 0, bias 0, window 8, empty history.
// A window_len write also empties the history; the store needs no clearing.
// ----------------------------------------------------------------------------
module accel_rotate_moving_average #(
  parameter int WINDOW_MAX  = arma_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = arma_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  arma_pkg::cfg_idx_t                cfg_idx,
  input  logic [arma_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [SAMPLE_BITS-1:0]     in_accel_x,
  input  logic signed [SAMPLE_BITS-1:0]     in_accel_y,
  input  logic signed [SAMPLE_BITS-1:0]     in_accel_z,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [SAMPLE_BITS-1:0]     out_avg_x,
  output logic signed [SAMPLE_BITS-1:0]     out_avg_y,
  output logic signed [SAMPLE_BITS-1:0]     out_avg_z
);

  // stored sample width: covers the sample range, the bias range and two
  // extra bits for negation plus bias
  localparam int BASE_W = (SAMPLE_BITS > arma_pkg::BIAS_W) ? SAMPLE_BITS
                                                           : arma_pkg::BIAS_W;
  localparam int SW     = BASE_W + 2;
  localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
  localparam int PTR_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SUM_W  = SW + LEN_W;
  localparam int CNT_W  = $clog2(SUM_W);
  localparam int LEN_RST = (arma_pkg::WLEN_RESET > WINDOW_MAX) ? WINDOW_MAX
                                                               : arma_pkg::WLEN_RESET;

  localparam logic [SUM_W-1:0] SAT_HI = SUM_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic [SUM_W-1:0] SAT_LO = SUM_W'(64'd1 << (SAMPLE_BITS - 1));

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUB  = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_LOAD = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  // configuration
  arma_pkg::rot_t                 rot_r;
  logic signed [arma_pkg::BIAS_W-1:0] bias_r;
  logic [LEN_W-1:0]               len_r;

  // control
  logic [2:0]                     state_r, state_nxt;
  logic [LEN_W-1:0]               fill_r;
  logic [PTR_W-1:0]               wp_r;
  logic                           full_r;
  logic [CNT_W-1:0]               cnt_r;

  // datapath
  logic [3*SW-1:0]                mem [WINDOW_MAX];
  logic [3*SW-1:0]                rd_r;
  logic signed [SW-1:0]           smp_r  [3];
  logic signed [SUM_W-1:0]        sum_r  [3];
  logic [SUM_W-1:0]               dq_r   [3];
  logic [LEN_W-1:0]               rem_r  [3];
  logic                           neg_r  [3];
  logic                           out_valid_r;
  logic [SAMPLE_BITS-1:0]         avg_r  [3];

  // combinational
  logic signed [SW-1:0]           ax_s, ay_s, az_s, wx_s, wy_s, bias_s;
  logic signed [SW-1:0]           smp_new [3];
  logic [SUM_W-1:0]               dq_nxt  [3];
  logic [LEN_W-1:0]               rem_nxt [3];
  logic [SAMPLE_BITS-1:0]         sat_val [3];
  logic [arma_pkg::WLEN_W-1:0]    unused_w;
  logic                           in_acc;
  logic                           out_load;
  logic [LEN_W-1:0]               len_cfg;

  assign in_acc   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  assign out_valid = out_valid_r;
  assign out_avg_x = avg_r[0];
  assign out_avg_y = avg_r[1];
  assign out_avg_z = avg_r[2];

  // effective window length from a write: zero acts as one, clamp at max
  assign unused_w = cfg_wdata[arma_pkg::WLEN_W-1:0];
  always_comb begin
    if (unused_w == '0) begin
      len_cfg = LEN_W'(1);
    end else if (int'(unused_w) > WINDOW_MAX) begin
      len_cfg = LEN_W'(WINDOW_MAX);
    end else begin
      len_cfg = LEN_W'(unused_w);
    end
  end

  // axis remap, world X negation and bias
  always_comb begin
    ax_s   = {{(SW-SAMPLE_BITS){in_accel_x[SAMPLE_BITS-1]}}, in_accel_x};
    ay_s   = {{(SW-SAMPLE_BITS){in_accel_y[SAMPLE_BITS-1]}}, in_accel_y};
    az_s   = {{(SW-SAMPLE_BITS){in_accel_z[SAMPLE_BITS-1]}}, in_accel_z};
    bias_s = {{(SW-arma_pkg::BIAS_W){bias_r[arma_pkg::BIAS_W-1]}}, bias_r};
    unique case (rot_r)
      arma_pkg::ROT_0: begin
        wx_s = ax_s;
        wy_s = ay_s;
      end
      arma_pkg::ROT_90: begin
        wx_s = -ay_s;
        wy_s = ax_s;
      end
      arma_pkg::ROT_180: begin
        wx_s = -ax_s;
        wy_s = -ay_s;
      end
      arma_pkg::ROT_270: begin
        wx_s = ay_s;
        wy_s = -ax_s;
      end
      default: begin
        wx_s = ax_s;
        wy_s = ay_s;
      end
    endcase
    smp_new[0] = bias_s - wx_s;
    smp_new[1] = wy_s;
    smp_new[2] = az_s;
  end

  // one restoring-division step per lane and the output saturation
  always_comb begin
    logic [LEN_W:0] trial;
    logic [SUM_W-1:0] q;
    for (int i = 0; i < 3; i++) begin
      trial = {rem_r[i], dq_r[i][SUM_W-1]};
      if (trial >= {1'b0, fill_r}) begin
        rem_nxt[i] = LEN_W'(trial - {1'b0, fill_r});
        dq_nxt[i]  = {dq_r[i][SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt[i] = trial[LEN_W-1:0];
        dq_nxt[i]  = {dq_r[i][SUM_W-2:0], 1'b0};
      end
      q = dq_r[i];
      if (!neg_r[i]) begin
        sat_val[i] = (q > SAT_HI) ? SAT_HI[SAMPLE_BITS-1:0] : q[SAMPLE_BITS-1:0];
      end else begin
        sat_val[i] = (q > SAT_LO) ? SAT_LO[SAMPLE_BITS-1:0]
                                  : SAMPLE_BITS'(-q);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_SUB;
      S_SUB:  state_nxt = S_ADD;
      S_ADD:  state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_DIV;
      S_DIV:  if (cnt_r == '0) state_nxt = S_OUT;
      S_OUT:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sample store: one write and one registered read port
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_r <= mem[wp_r];
    end
    if (state_r == S_SUB) begin
      mem[wp_r] <= {smp_r[2], smp_r[1], smp_r[0]};
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < 3; i++) smp_r[i] <= smp_new[i];
    end
    if (state_r == S_LOAD) begin
      for (int i = 0; i < 3; i++) begin
        neg_r[i] <= sum_r[i][SUM_W-1];
        dq_r[i]  <= sum_r[i][SUM_W-1] ? SUM_W'(-sum_r[i]) : SUM_W'(sum_r[i]);
        rem_r[i] <= '0;
      end
    end else if (state_r == S_DIV) begin
      for (int i = 0; i < 3; i++) begin
        dq_r[i]  <= dq_nxt[i];
        rem_r[i] <= rem_nxt[i];
      end
    end
    if (out_load) begin
      for (int i = 0; i < 3; i++) avg_r[i] <= sat_val[i];
    end
  end

  // control and running sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rot_r       <= arma_pkg::ROT_0;
      bias_r      <= '0;
      len_r       <= LEN_W'(LEN_RST);
      fill_r      <= '0;
      wp_r        <= '0;
      full_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) sum_r[i] <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (out_valid_r && out_stall) || out_load;

      if (cfg_we) begin
        unique case (cfg_idx)
          arma_pkg::REG_ROTATION:   rot_r  <= cfg_wdata[1:0];
          arma_pkg::REG_X_BIAS:     bias_r <= cfg_wdata[arma_pkg::BIAS_W-1:0];
          arma_pkg::REG_WINDOW_LEN: begin
            len_r  <= len_cfg;
            fill_r <= '0;
            wp_r   <= '0;
            for (int i = 0; i < 3; i++) sum_r[i] <= '0;
          end
          default: ;
        endcase
      end

      if (in_acc) begin
        full_r <= (fill_r >= len_r);
      end

      // drop the oldest sample, advance pointer and fill count
      if (state_r == S_SUB) begin
        if (full_r) begin
          for (int i = 0; i < 3; i++) begin
            sum_r[i] <= sum_r[i] - SUM_W'(signed'(rd_r[i*SW +: SW]));
          end
        end else begin
          fill_r <= fill_r + LEN_W'(1);
        end
        wp_r <= (LEN_W'(wp_r) + LEN_W'(1) == len_r) ? '0 : wp_r + PTR_W'(1);
      end

      if (state_r == S_ADD) begin
        for (int i = 0; i < 3; i++) sum_r[i] <= sum_r[i] + SUM_W'(smp_r[i]);
      end

      if (state_r == S_LOAD) begin
        cnt_r <= CNT_W'(SUM_W - 1);
      end else if (state_r == S_DIV) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

>>> hdl/arma_checker.sv
// ----------------------------------------------------------------------------
// arma_checker
// Port-level checks for the accelerometer remap and moving average block.
// ----------------------------------------------------------------------------
module arma_checker #(
  parameter int SAMPLE_BITS = arma_pkg::SAMPLE_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [SAMPLE_BITS-1:0] out_avg_x,
  input logic [SAMPLE_BITS-1:0] out_avg_y,
  input logic [SAMPLE_BITS-1:0] out_avg_z
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_avg_x) &&
                               $stable(out_avg_y) && $stable(out_avg_z))
    else $error("stalled result beat changed");

  // reset leaves the block empty and ready
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // one sample at a time: input is held off right after a beat is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a sample is in flight");

  // the divide lies between input and result: no result can show the cycle after a beat
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too early");

endmodule

bind accel_rotate_moving_average arma_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_arma_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_avg_x (out_avg_x),
  .out_avg_y (out_avg_y),
  .out_avg_z (out_avg_z)
);

>>> dv/accel_rotate_moving_average_tb.sv
// ----------------------------------------------------------------------------
// accel_rotate_moving_average_tb
// Drives three-axis samples through the remap and moving-average block under
// random valid and stall gaps on both channels. Each accepted sample runs
// through a local window model. Every result beat is compared per axis with
// the oldest predicted mean. A short table of directed samples comes first:
// all rotations, bias and sample extremes, saturation, out-of-range window
// lengths and the window wrap. Random phases follow, each under new register
// settings.
// ----------------------------------------------------------------------------
module accel_rotate_moving_average_tb;

  localparam int SB      = arma_pkg::SAMPLE_BITS_DEF;
  localparam int WIN_MAX = arma_pkg::WINDOW_MAX_DEF;

  typedef struct packed {
    logic signed [SB-1:0] x;
    logic signed [SB-1:0] y;
    logic signed [SB-1:0] z;
  } accel_mean_t;

  typedef struct packed {
    bit                              setup;
    arma_pkg::rot_t                  rot;
    logic [arma_pkg::BIAS_W-1:0]     bias;
    logic [arma_pkg::WLEN_W-1:0]     wlen;
    logic signed [SB-1:0]            ax;
    logic signed [SB-1:0]            ay;
    logic signed [SB-1:0]            az;
    bit                              known;
    logic signed [SB-1:0]            ex;
    logic signed [SB-1:0]            ey;
    logic signed [SB-1:0]            ez;
  } sample_row_t;

  // setup rows drain the block and rewrite all three registers first;
  // known rows carry a hand-worked mean
  localparam int DIR_ROWS = 24;
  localparam sample_row_t SAMPLE_TABLE [DIR_ROWS] = '{
    '{1'b0, arma_pkg::ROT_0,   0,      8,   256,   512,    768,   1'b1, -256,   512,    768},
    '{1'b0, arma_pkg::ROT_0,   0,      8,   768,   0,      -768,  1'b1, -512,   256,    0},
    '{1'b1, arma_pkg::ROT_0,   0,      1,   32767, -32768, 32767, 1'b1, -32767, -32768, 32767},
    '{1'b0, arma_pkg::ROT_0,   0,      1,  -32768, 32767, -32768, 1'b1, 32767,  32767, -32768},
    '{1'b1, arma_pkg::ROT_90,  0,      1,   100,   200,    5,     1'b1, 200,    100,    5},
    '{1'b0, arma_pkg::ROT_90,  0,      1,  -32768, -32768, 0,     1'b1, -32768, -32768, 0},
    '{1'b1, arma_pkg::ROT_180, 0,      1,   300,   -400,   7,     1'b1, 300,    400,    7},
    '{1'b0, arma_pkg::ROT_180, 0,      1,  -32768, -32768, -1,    1'b1, -32768, 32767,  -1},
    '{1'b1, arma_pkg::ROT_270, 0,      1,   50,    60,     70,    1'b1, -60,    -50,    70},
    '{1'b0, arma_pkg::ROT_270, 0,      1,  -32768, 32767,  0,     1'b1, -32767, 32767,  0},
    '{1'b1, arma_pkg::ROT_0,   32767,  1,  -32768, 0,      0,     1'b1, 32767,  0,      0},
    '{1'b0, arma_pkg::ROT_0,   32767,  1,   32767, 0,      0,     1'b1, 0,      0,      0},
    '{1'b1, arma_pkg::ROT_0,   -32768, 1,   32767, 0,      0,     1'b1, -32768, 0,      0},
    '{1'b1, arma_pkg::ROT_0,   0,      0,   10,    20,     30,    1'b1, -10,    20,     30},
    '{1'b0, arma_pkg::ROT_0,   0,      0,   40,    50,     60,    1'b1, -40,    50,     60},
    '{1'b1, arma_pkg::ROT_0,   0,      127, 1,     1,      1,     1'b1, -1,     1,      1},
    '{1'b0, arma_pkg::ROT_0,   0,      127, 2,     2,      2,     1'b1, -1,     1,      1},
    '{1'b1, arma_pkg::ROT_0,   0,      3,   -1,    -1,     -1,    1'b1, 1,      -1,     -1},
    '{1'b0, arma_pkg::ROT_0,   0,      3,   -1,    -2,     0,     1'b1, 1,      -1,     0},
    '{1'b0, arma_pkg::ROT_0,   0,      3,   0,     0,      0,     1'b1, 0,      -1,     0},
    '{1'b0, arma_pkg::ROT_0,   0,      3,   4,     4,      4,     1'b1, -1,     0,      1},
    '{1'b0, arma_pkg::ROT_0,   0,      3,   5,     -7,     9,     1'b0, 0,      0,      0},
    '{1'b1, arma_pkg::ROT_90,  16'h1234, 64, 1000, -2000,  3000,  1'b0, 0,      0,      0},
    '{1'b1, arma_pkg::ROT_180, -100,   2,   -5000, 6000,   32767, 1'b0, 0,      0,      0}
  };

  // settings of the first four random phases, among them bias and window extremes
  localparam logic [arma_pkg::BIAS_W-1:0] PHASE_BIAS [4] =
    '{16'h7FFF, 16'h8000, 16'h0000, 16'h00C0};
  localparam logic [arma_pkg::WLEN_W-1:0] PHASE_WLEN [4] = '{7'd64, 7'd1, 7'd127, 7'd5};
  localparam int PHASES          = 7;
  localparam int BEATS_PER_PHASE = 250;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  arma_pkg::cfg_idx_t              cfg_idx;
  logic [arma_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                            in_valid;
  logic                            in_stall;
  logic signed [SB-1:0]            in_accel_x;
  logic signed [SB-1:0]            in_accel_y;
  logic signed [SB-1:0]            in_accel_z;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic signed [SB-1:0]            out_avg_x;
  logic signed [SB-1:0]            out_avg_y;
  logic signed [SB-1:0]            out_avg_z;

  // window model
  arma_pkg::rot_t                     cur_rot;
  logic signed [arma_pkg::BIAS_W-1:0] cur_bias;
  logic [arma_pkg::WLEN_W-1:0]        cur_wlen;
  logic signed [17:0]                 win_x [WIN_MAX];
  logic signed [17:0]                 win_y [WIN_MAX];
  logic signed [17:0]                 win_z [WIN_MAX];
  logic signed [23:0]                 acc_x, acc_y, acc_z;
  int                                 fill;
  int                                 wr_ptr;

  accel_mean_t mean_q [$];
  int          mismatch_count = 0;
  int          idle_pct = 35;

  accel_rotate_moving_average dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_accel_x (in_accel_x),
    .in_accel_y (in_accel_y),
    .in_accel_z (in_accel_z),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_avg_x  (out_avg_x),
    .out_avg_y  (out_avg_y),
    .out_avg_z  (out_avg_z)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic void clear_window();
    acc_x  = '0;
    acc_y  = '0;
    acc_z  = '0;
    fill   = 0;
    wr_ptr = 0;
  endfunction

  function automatic logic signed [SB-1:0] clamp16(input int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[SB-1:0];
  endfunction

  // remap, bias and push one sample; return the new per-axis means
  function automatic accel_mean_t advance_window(input logic signed [SB-1:0] ax, ay, az);
    logic signed [17:0] dx, dy, wx, wy, nx, bias_ext;
    int                 len;
    int                 slot;
    accel_mean_t        m;
    dx       = ax;
    dy       = ay;
    bias_ext = cur_bias;
    case (cur_rot)
      arma_pkg::ROT_0: begin
        wx = dx;
        wy = dy;
      end
      arma_pkg::ROT_90: begin
        wx = -dy;
        wy = dx;
      end
      arma_pkg::ROT_180: begin
        wx = -dx;
        wy = -dy;
      end
      default: begin
        wx = dy;
        wy = -dx;
      end
    endcase
    nx   = bias_ext - wx;
    len  = (cur_wlen == 0) ? 1 : ((cur_wlen > WIN_MAX) ? WIN_MAX : int'(cur_wlen));
    slot = wr_ptr % len;
    if (fill >= len) begin
      // drop the oldest sample
      acc_x = acc_x - win_x[slot];
      acc_y = acc_y - win_y[slot];
      acc_z = acc_z - win_z[slot];
      fill  = len;
    end else begin
      fill++;
    end
    win_x[slot] = nx;
    win_y[slot] = wy;
    win_z[slot] = az;
    acc_x  = acc_x + nx;
    acc_y  = acc_y + wy;
    acc_z  = acc_z + az;
    wr_ptr = (slot + 1) % len;
    m.x = clamp16(int'(acc_x) / fill);
    m.y = clamp16(int'(acc_y) / fill);
    m.z = clamp16(int'(acc_z) / fill);
    return m;
  endfunction

  function automatic void compare_axis(input string axis, input logic signed [SB-1:0] want,
                                       input logic signed [SB-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, axis, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic logic signed [SB-1:0] pick_axis();
    case ($urandom_range(9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      3:       return 16'shFFFF;
      default: return SB'($urandom);
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after the beat
  task automatic send_sample(input logic signed [SB-1:0] ax, ay, az,
                             input bit use_typed, input accel_mean_t typed);
    accel_mean_t m;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_accel_x <= ax;
    in_accel_y <= ay;
    in_accel_z <= az;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    m = advance_window(ax, ay, az);
    mean_q.insert(mean_q.size(), use_typed ? typed : m);
    @(negedge clk);
  endtask

  // hold the input until every predicted mean has come out
  task automatic await_quiet();
    in_valid <= 1'b0;
    while (mean_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input arma_pkg::cfg_idx_t idx,
                           input logic [arma_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  task automatic apply_setup(input arma_pkg::rot_t rot,
                             input logic [arma_pkg::BIAS_W-1:0] bias,
                             input logic [arma_pkg::WLEN_W-1:0] wlen);
    await_quiet();
    write_reg(arma_pkg::REG_ROTATION, arma_pkg::CFG_DATA_W'(rot));
    write_reg(arma_pkg::REG_X_BIAS, bias);
    write_reg(arma_pkg::REG_WINDOW_LEN, arma_pkg::CFG_DATA_W'(wlen));
    cfg_we   <= 1'b0;
    cur_rot  = rot;
    cur_bias = bias;
    cur_wlen = wlen;
    clear_window();
  endtask

  always @(negedge clk) begin
    out_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk) begin
    accel_mean_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (mean_q.size() == 0) begin
        $display("%0t: unexpected beat: expected none, actual %0d %0d %0d",
                 $time, out_avg_x, out_avg_y, out_avg_z);
        mismatch_count++;
      end else begin
        want = mean_q.pop_front();
        compare_axis("avg_x", want.x, out_avg_x);
        compare_axis("avg_y", want.y, out_avg_y);
        compare_axis("avg_z", want.z, out_avg_z);
      end
    end
  end

  initial begin
    sample_row_t                 row;
    accel_mean_t                 typed;
    logic [arma_pkg::WLEN_W-1:0] rnd_wlen;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_idx    = arma_pkg::REG_ROTATION;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    in_accel_x = '0;
    in_accel_y = '0;
    in_accel_z = '0;
    cur_rot    = arma_pkg::ROT_0;
    cur_bias   = '0;
    cur_wlen   = arma_pkg::WLEN_W'(arma_pkg::WLEN_RESET);
    clear_window();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = SAMPLE_TABLE[i];
      if (row.setup) apply_setup(row.rot, row.bias, row.wlen);
      typed.x = row.ex;
      typed.y = row.ey;
      typed.z = row.ez;
      send_sample(row.ax, row.ay, row.az, row.known, typed);
    end

    typed = '0;
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 4) begin
        apply_setup(arma_pkg::rot_t'(ph), PHASE_BIAS[ph], PHASE_WLEN[ph]);
      end else begin
        rnd_wlen = arma_pkg::WLEN_W'($urandom_range(127));
        if (rnd_wlen[0]) rnd_wlen = arma_pkg::WLEN_W'($urandom_range(1, 8));
        apply_setup(arma_pkg::rot_t'($urandom_range(3)), arma_pkg::BIAS_W'($urandom),
                    rnd_wlen);
      end
      // phase 1 runs with no gaps on either side
      idle_pct = (ph == 1) ? 0 : 35;
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        if (ph == 3 && n == BEATS_PER_PHASE / 2) await_quiet();
        send_sample(pick_axis(), pick_axis(), pick_axis(), 1'b0, typed);
      end
    end

    await_quiet();
    repeat (40) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("accel_rotate_moving_average regression: pass");
    end else begin
      $display("accel_rotate_moving_average regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("accel_rotate_moving_average regression: fail");
    $finish;
  end

endmodule
